@@ src/vra_pkg.sv @@
`default_nettype none

package vra_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 20;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 31;

  localparam logic [1:0] CMD_X    = 2'd0;
  localparam logic [1:0] CMD_Y    = 2'd1;
  localparam logic [1:0] CMD_Z    = 2'd2;
  localparam logic [1:0] CMD_AXIS = 2'd3;

  localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;
  localparam logic signed [32:0] PI_Q30       = 33'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

  localparam logic signed [32:0] ATAN_Q30 [30] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158, 33'sd67021686,
    33'sd33543515, 33'sd16775850, 33'sd8388437, 33'sd4194282, 33'sd2097149,
    33'sd1048575, 33'sd524287, 33'sd262143, 33'sd131071, 33'sd65535,
    33'sd32767, 33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
    33'sd1023, 33'sd511, 33'sd255, 33'sd127, 33'sd63,
    33'sd31, 33'sd15, 33'sd8, 33'sd4, 33'sd2
  };

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] angle;
  } item_t;

  typedef struct packed {
    item_t            item;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][31:0] m;
    logic [63:0]      rad;
    logic [63:0]      root;
  } sq_t;

  typedef struct packed {
    item_t            item;
    logic [2:0]       neg;
    logic             zero;
    logic [31:0]      len;
    logic [2:0][33:0] rem;
    logic [2:0][30:0] quo;
  } dv_t;

  typedef struct packed {
    item_t              item;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cd_t;

endpackage

`default_nettype wire

@@ src/vra_sqrt_cell.sv @@
`default_nettype none

module vra_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  wire logic          vld_i,
  input  wire vra_pkg::sq_t  dat_i,
  output logic               vld_o,
  output vra_pkg::sq_t       dat_o
);

  logic [63:0]   step_w;
  logic [63:0]   trial_w;
  vra_pkg::sq_t  dat_d;
  vra_pkg::sq_t  dat_q;
  logic          vld_q;

  assign step_w  = 64'd1 << (7'd62 - 7'({idx_i, 1'b0}));
  assign trial_w = dat_i.root + step_w;

  always_comb begin
    dat_d = dat_i;
    if (dat_i.rad >= trial_w) begin
      dat_d.rad  = dat_i.rad - trial_w;
      dat_d.root = (dat_i.root >> 1) + step_w;
    end else begin
      dat_d.root = dat_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

`default_nettype wire

@@ src/vra_div_cell.sv @@
`default_nettype none

module vra_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  wire logic          vld_i,
  input  wire vra_pkg::dv_t  dat_i,
  output logic               vld_o,
  output vra_pkg::dv_t       dat_o
);

  vra_pkg::dv_t  dat_d;
  vra_pkg::dv_t  dat_q;
  logic          vld_q;

  always_comb begin
    logic [33:0] sh;
    logic        ge;
    dat_d = dat_i;
    for (int k = 0; k < 3; k++) begin
      sh = (idx_i == 5'd0) ? dat_i.rem[k] : {dat_i.rem[k][32:0], 1'b0};
      ge = sh >= {2'b00, dat_i.len};
      dat_d.rem[k] = ge ? sh - {2'b00, dat_i.len} : sh;
      dat_d.quo[k] = {dat_i.quo[k][29:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

`default_nettype wire

@@ src/vra_cordic_cell.sv @@
`default_nettype none

module vra_cordic_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  wire logic          vld_i,
  input  wire vra_pkg::cd_t  dat_i,
  output logic               vld_o,
  output vra_pkg::cd_t       dat_o
);

  logic signed [33:0] dx_w;
  logic signed [33:0] dy_w;
  vra_pkg::cd_t       dat_d;
  vra_pkg::cd_t       dat_q;
  logic               vld_q;

  assign dx_w = dat_i.y >>> idx_i;
  assign dy_w = dat_i.x >>> idx_i;

  always_comb begin
    dat_d = dat_i;
    if (!dat_i.z[32]) begin
      dat_d.x = dat_i.x - dx_w;
      dat_d.y = dat_i.y + dy_w;
      dat_d.z = dat_i.z - vra_pkg::ATAN_Q30[idx_i];
    end else begin
      dat_d.x = dat_i.x + dx_w;
      dat_d.y = dat_i.y - dy_w;
      dat_d.z = dat_i.z + vra_pkg::ATAN_Q30[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

`default_nettype wire

@@ src/vec3_rotate_axis_angle.sv @@
// Channel   Direction  Handshake                  Payload
// in        to block   in_valid_i / in_stall_o    command_i, vec_*_i, angle_i, axis_*_i
// out       from block out_valid_o / out_stall_i  out_x_o, out_y_o, out_z_o
//
// One transfer is taken per cycle while in_stall_o is low.
// The pipeline holds the 32 square root cells, the 31 division cells and the CORDIC cells.
// Reset clears only the valid bits of the pipeline; no clearing pass is needed.
// A stalled result freezes the whole pipeline, so in_stall_o follows out_stall_i then.
`default_nettype none

module vec3_rotate_axis_angle (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         command_i,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  input  wire logic signed [31:0] angle_i,
  input  wire logic signed [31:0] axis_x_i,
  input  wire logic signed [31:0] axis_y_i,
  input  wire logic signed [31:0] axis_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o
);

  localparam logic [1:0] CMD_X    = vra_pkg::CMD_X;
  localparam logic [1:0] CMD_Y    = vra_pkg::CMD_Y;
  localparam logic [1:0] CMD_AXIS = vra_pkg::CMD_AXIS;

  localparam int SQN = vra_pkg::SQRT_STEPS;
  localparam int DVN = vra_pkg::DIV_STEPS;
  localparam int CDN = vra_pkg::CORDIC_STAGES;
  localparam int FB  = vra_pkg::FRAC_BITS;

  function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    return p[65:30];
  endfunction

  function automatic logic signed [32:0] clamp2(input logic signed [35:0] v);
    logic signed [32:0] r;
    if (v > 36'sd2147483648) begin
      r = 33'sd2147483648;
    end else if (v < -36'sd2147483648) begin
      r = -33'sd2147483648;
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Axis magnitude and leading-zero normalization.
  vra_pkg::item_t   n1_item_q, n2_item_q, n3_item_q, n4_item_q, n5_item_q;
  logic [2:0]       n1_neg_q, n2_neg_q, n3_neg_q, n4_neg_q, n5_neg_q;
  logic             n1_zero_q, n2_zero_q, n3_zero_q, n4_zero_q, n5_zero_q;
  logic [2:0][31:0] m_d, n1_m_q, n2_m_q, n3_m_q, n4_m_q, n5_m_q;
  logic [31:0]      big_d, n1_big_q;
  logic [4:0]       sh_d, n2_sh_q;
  logic [2:0][63:0] n4_sq_q;
  logic [63:0]      n5_sum_q;
  logic [4:0]       nv_q;
  logic [2:0]       neg_d;

  always_comb begin
    neg_d[0] = axis_x_i[31];
    neg_d[1] = axis_y_i[31];
    neg_d[2] = axis_z_i[31];
    m_d[0] = neg_d[0] ? 32'(-axis_x_i) : axis_x_i;
    m_d[1] = neg_d[1] ? 32'(-axis_y_i) : axis_y_i;
    m_d[2] = neg_d[2] ? 32'(-axis_z_i) : axis_z_i;
    big_d = (m_d[0] > m_d[1]) ? m_d[0] : m_d[1];
    if (m_d[2] > big_d) begin
      big_d = m_d[2];
    end
  end

  always_comb begin
    sh_d = 5'd0;
    for (int b = 0; b < 30; b++) begin
      if (n1_big_q[b]) begin
        sh_d = 5'(30 - b);
      end
    end
    if (n1_big_q[31] || n1_big_q[30]) begin
      sh_d = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
    end else if (en) begin
      nv_q <= {nv_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_item_q <= '{cmd: command_i, vx: vec_x_i, vy: vec_y_i, vz: vec_z_i, angle: angle_i};
      n1_neg_q  <= neg_d;
      n1_m_q    <= m_d;
      n1_big_q  <= big_d;
      n1_zero_q <= big_d == 32'd0;
      n2_item_q <= n1_item_q;
      n2_neg_q  <= n1_neg_q;
      n2_zero_q <= n1_zero_q;
      n2_m_q    <= n1_m_q;
      n2_sh_q   <= sh_d;
      n3_item_q <= n2_item_q;
      n3_neg_q  <= n2_neg_q;
      n3_zero_q <= n2_zero_q;
      for (int k = 0; k < 3; k++) begin
        n3_m_q[k]  <= n2_m_q[k] << n2_sh_q;
        n4_sq_q[k] <= 64'(n3_m_q[k]) * 64'(n3_m_q[k]);
      end
      n4_item_q <= n3_item_q;
      n4_neg_q  <= n3_neg_q;
      n4_zero_q <= n3_zero_q;
      n4_m_q    <= n3_m_q;
      n5_item_q <= n4_item_q;
      n5_neg_q  <= n4_neg_q;
      n5_zero_q <= n4_zero_q;
      n5_m_q    <= n4_m_q;
      n5_sum_q  <= n4_sq_q[0] + n4_sq_q[1] + n4_sq_q[2];
    end
  end

  // Square root chain.
  vra_pkg::sq_t sq_pipe [SQN+1];
  logic         sq_vld  [SQN+1];

  assign sq_vld[0]  = nv_q[4];
  assign sq_pipe[0] = '{item: n5_item_q, neg: n5_neg_q, zero: n5_zero_q, m: n5_m_q,
                        rad: n5_sum_q, root: 64'd0};

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    vra_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (5'(i)),
      .vld_i  (sq_vld[i]),
      .dat_i  (sq_pipe[i]),
      .vld_o  (sq_vld[i+1]),
      .dat_o  (sq_pipe[i+1])
    );
  end

  // Division chain for the unit axis.
  vra_pkg::dv_t dv_pipe [DVN+1];
  logic         dv_vld  [DVN+1];

  assign dv_vld[0] = sq_vld[SQN];
  always_comb begin
    dv_pipe[0].item = sq_pipe[SQN].item;
    dv_pipe[0].neg  = sq_pipe[SQN].neg;
    dv_pipe[0].zero = sq_pipe[SQN].zero;
    dv_pipe[0].len  = sq_pipe[SQN].root[31:0];
    for (int k = 0; k < 3; k++) begin
      dv_pipe[0].rem[k] = {2'b00, sq_pipe[SQN].m[k]};
      dv_pipe[0].quo[k] = 31'd0;
    end
  end

  for (genvar i = 0; i < DVN; i++) begin : g_div
    vra_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (5'(i)),
      .vld_i  (dv_vld[i]),
      .dat_i  (dv_pipe[i]),
      .vld_o  (dv_vld[i+1]),
      .dat_o  (dv_pipe[i+1])
    );
  end

  // Phase, quadrant and CORDIC start angle.
  vra_pkg::item_t     a1_item_q, a2_item_q, a3_item_q;
  logic signed [31:0] a1_n_q [3];
  logic signed [31:0] a2_n_q [3];
  logic signed [31:0] a3_n_q [3];
  logic signed [63:0] a1_prod_q;
  logic [31:0]        phase_d, wrap_d;
  logic [1:0]         a2_quad_q, a3_quad_q;
  logic signed [30:0] a2_r_q;
  logic signed [63:0] zp_d;
  logic signed [32:0] a3_z_q;
  logic [2:0]         av_q;

  assign phase_d = (a1_item_q.cmd == CMD_AXIS) ? a1_prod_q[FB+1 +: 32]
                                               : a1_prod_q[FB +: 32];
  assign wrap_d  = phase_d + 32'h2000_0000;
  assign zp_d    = a2_r_q * vra_pkg::PI_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= '0;
    end else if (en) begin
      av_q <= {av_q[1:0], dv_vld[DVN]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_item_q <= dv_pipe[DVN].item;
      a1_prod_q <= 64'($signed(dv_pipe[DVN].item.angle)
                       * $signed({2'b00, vra_pkg::TURN_PER_RAD}));
      for (int k = 0; k < 3; k++) begin
        if (dv_pipe[DVN].zero) begin
          a1_n_q[k] <= 32'sd0;
        end else if (dv_pipe[DVN].neg[k]) begin
          a1_n_q[k] <= -$signed({1'b0, dv_pipe[DVN].quo[k]});
        end else begin
          a1_n_q[k] <= $signed({1'b0, dv_pipe[DVN].quo[k]});
        end
      end
      a2_item_q <= a1_item_q;
      a2_n_q    <= a1_n_q;
      a2_quad_q <= wrap_d[31:30];
      a2_r_q    <= $signed({1'b0, wrap_d[29:0]}) - 31'sd536870912;
      a3_item_q <= a2_item_q;
      a3_n_q    <= a2_n_q;
      a3_quad_q <= a2_quad_q;
      a3_z_q    <= zp_d[63:31];
    end
  end

  // CORDIC chain.
  vra_pkg::cd_t cd_pipe [CDN+1];
  logic         cd_vld  [CDN+1];

  assign cd_vld[0]  = av_q[2];
  assign cd_pipe[0] = '{item: a3_item_q, nx: a3_n_q[0], ny: a3_n_q[1], nz: a3_n_q[2],
                        quad: a3_quad_q, x: vra_pkg::GAIN_Q30, y: 34'sd0, z: a3_z_q};

  for (genvar i = 0; i < CDN; i++) begin : g_cordic
    vra_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (5'(i)),
      .vld_i  (cd_vld[i]),
      .dat_i  (cd_pipe[i]),
      .vld_o  (cd_vld[i+1]),
      .dat_o  (cd_pipe[i+1])
    );
  end

  // Quaternion, rotation matrix and matrix product.
  vra_pkg::cd_t       cd_last;
  logic signed [33:0] c_d, s_d;
  logic [1:0]         q1_cmd_q, q2_cmd_q, q3_cmd_q;
  logic signed [31:0] q1_v_q [3];
  logic signed [31:0] q2_v_q [3];
  logic signed [31:0] q3_v_q [3];
  logic signed [33:0] q1_c_q, q1_s_q, q2_c_q, q2_s_q;
  logic signed [33:0] q1_q_q [4];
  logic signed [35:0] p00_q, p11_q, p22_q, p33_q;
  logic signed [35:0] p12_q, p03_q, p13_q, p02_q, p23_q, p01_q;
  logic signed [35:0] mx_d [9];
  logic signed [32:0] q3_m_q [9];
  logic signed [34:0] m1_pr_q [9];
  logic signed [36:0] acc_d [3];
  logic signed [31:0] sat_d [3];
  logic [3:0]         qv_q;

  assign cd_last = cd_pipe[CDN];

  always_comb begin
    case (cd_last.quad)
      2'd0: begin
        c_d = cd_last.x;
        s_d = cd_last.y;
      end
      2'd1: begin
        c_d = -cd_last.y;
        s_d = cd_last.x;
      end
      2'd2: begin
        c_d = -cd_last.x;
        s_d = -cd_last.y;
      end
      default: begin
        c_d = cd_last.y;
        s_d = -cd_last.x;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mx_d[k] = 36'sd0;
    end
    if (q2_cmd_q == CMD_AXIS) begin
      mx_d[0] = p00_q + p11_q - p22_q - p33_q;
      mx_d[1] = (p12_q - p03_q) <<< 1;
      mx_d[2] = (p13_q + p02_q) <<< 1;
      mx_d[3] = (p12_q + p03_q) <<< 1;
      mx_d[4] = p00_q - p11_q + p22_q - p33_q;
      mx_d[5] = (p23_q - p01_q) <<< 1;
      mx_d[6] = (p13_q - p02_q) <<< 1;
      mx_d[7] = (p23_q + p01_q) <<< 1;
      mx_d[8] = p00_q - p11_q - p22_q + p33_q;
    end else if (q2_cmd_q == CMD_X) begin
      mx_d[0] = 36'(vra_pkg::ONE_Q30);
      mx_d[4] = 36'(q2_c_q);
      mx_d[5] = -36'(q2_s_q);
      mx_d[7] = 36'(q2_s_q);
      mx_d[8] = 36'(q2_c_q);
    end else if (q2_cmd_q == CMD_Y) begin
      mx_d[0] = 36'(q2_c_q);
      mx_d[2] = 36'(q2_s_q);
      mx_d[4] = 36'(vra_pkg::ONE_Q30);
      mx_d[6] = -36'(q2_s_q);
      mx_d[8] = 36'(q2_c_q);
    end else begin
      mx_d[0] = 36'(q2_c_q);
      mx_d[1] = -36'(q2_s_q);
      mx_d[3] = 36'(q2_s_q);
      mx_d[4] = 36'(q2_c_q);
      mx_d[8] = 36'(vra_pkg::ONE_Q30);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = 37'(m1_pr_q[3*i]) + 37'(m1_pr_q[3*i+1]) + 37'(m1_pr_q[3*i+2]);
      if (acc_d[i] > 37'sd2147483647) begin
        sat_d[i] = 32'sh7fff_ffff;
      end else if (acc_d[i] < -37'sd2147483648) begin
        sat_d[i] = 32'sh8000_0000;
      end else begin
        sat_d[i] = acc_d[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q        <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      qv_q        <= {qv_q[2:0], cd_vld[CDN]};
      out_valid_o <= qv_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [64:0] t;
    if (en) begin
      q1_cmd_q  <= cd_last.item.cmd;
      q1_v_q[0] <= cd_last.item.vx;
      q1_v_q[1] <= cd_last.item.vy;
      q1_v_q[2] <= cd_last.item.vz;
      q1_c_q    <= c_d;
      q1_s_q    <= s_d;
      q1_q_q[0] <= c_d;
      q1_q_q[1] <= 34'(mul_q30(s_d, 34'(cd_last.nx)));
      q1_q_q[2] <= 34'(mul_q30(s_d, 34'(cd_last.ny)));
      q1_q_q[3] <= 34'(mul_q30(s_d, 34'(cd_last.nz)));

      q2_cmd_q <= q1_cmd_q;
      q2_v_q   <= q1_v_q;
      q2_c_q   <= q1_c_q;
      q2_s_q   <= q1_s_q;
      p00_q    <= mul_q30(q1_q_q[0], q1_q_q[0]);
      p11_q    <= mul_q30(q1_q_q[1], q1_q_q[1]);
      p22_q    <= mul_q30(q1_q_q[2], q1_q_q[2]);
      p33_q    <= mul_q30(q1_q_q[3], q1_q_q[3]);
      p12_q    <= mul_q30(q1_q_q[1], q1_q_q[2]);
      p03_q    <= mul_q30(q1_q_q[0], q1_q_q[3]);
      p13_q    <= mul_q30(q1_q_q[1], q1_q_q[3]);
      p02_q    <= mul_q30(q1_q_q[0], q1_q_q[2]);
      p23_q    <= mul_q30(q1_q_q[2], q1_q_q[3]);
      p01_q    <= mul_q30(q1_q_q[0], q1_q_q[1]);

      q3_cmd_q <= q2_cmd_q;
      q3_v_q   <= q2_v_q;
      for (int k = 0; k < 9; k++) begin
        q3_m_q[k] <= clamp2(mx_d[k]);
      end

      for (int k = 0; k < 9; k++) begin
        t = q3_m_q[k] * q3_v_q[k % 3];
        m1_pr_q[k] <= t[64:30];
      end

      out_x_o <= sat_d[0];
      out_y_o <= sat_d[1];
      out_z_o <= sat_d[2];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> out_valid_o && $stable(out_x_o) && $stable(out_z_o))
    else $error("held result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv_q[2] && !n3_zero_q |-> (n3_m_q[0][31:30] != 2'b00) || (n3_m_q[1][31:30] != 2'b00)
                              || (n3_m_q[2][31:30] != 2'b00))
    else $error("axis normalization left the largest magnitude below one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld[SQN] && !sq_pipe[SQN].zero |-> sq_pipe[SQN].root[63:30] != 34'd0)
    else $error("axis length below one for a nonzero axis");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[DVN] && !dv_pipe[DVN].zero |-> dv_pipe[DVN].quo[0] <= 31'd1073741824
      && dv_pipe[DVN].quo[1] <= 31'd1073741824 && dv_pipe[DVN].quo[2] <= 31'd1073741824)
    else $error("unit axis component above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q3_cmd_q == CMD_X && $past(en) && qv_q[2] |-> q3_m_q[0] == 33'sd1073741824)
    else $error("x rotation matrix lost its fixed diagonal entry");

endmodule

`default_nettype wire
